// ===== rtl/rbfk_pkg.sv =====
// Package for the RBF kernel value and gradient block.
// Holds shared constants and the controller/datapath command and status types.
// No dependencies.
`timescale 1ns / 1ps
package rbfk_pkg;

	localparam int unsigned DIV_W = 56;
	localparam int unsigned DIV_CNT_W = 6;
	localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
	localparam logic [DIV_W-1:0] EXP_LIMIT = 56'd786432;
	localparam logic [17:0] VAL_MAX = 18'd32768;
	localparam logic [DIV_W-1:0] SAT_POS = 56'd2147483647;
	localparam logic [DIV_W-1:0] SAT_NEG = 56'd2147483648;
	// ceil(2^35 / 6): exact floor division by six for any 32-bit operand
	localparam logic [32:0] RECIP_SIX = 33'h1_5555_5556;

	localparam logic [1:0] SEL_R = 2'd0;
	localparam logic [1:0] SEL_G = 2'd2;

	typedef struct packed {
		logic       load;
		logic       div_go;
		logic [1:0] div_sel;
		logic       cap_s;
		logic       mul_s2;
		logic       mul_s3;
		logic       div_six;
		logic       set_p;
		logic       square;
		logic       set_val;
		logic       rd;
		logic       emit;
	} rbfk_cmd_t;

	typedef struct packed {
		logic div_done;
		logic sq_last;
		logic idx_last;
	} rbfk_stat_t;

endpackage

// ===== rtl/rbfk_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module rbfk_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== rtl/rbfk_div.sv =====
// Iterative restoring divider, one quotient bit per cycle, 56-bit dividend.
// Depends on rbfk_pkg.
`timescale 1ns / 1ps
module rbfk_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      go,
	input  logic [rbfk_pkg::DIV_W-1:0] dividend,
	input  logic [31:0]               divisor,
	output logic                      done,
	output logic [rbfk_pkg::DIV_W-1:0] quotient
);
	import rbfk_pkg::*;

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [31:0]          rem_q;
	logic [31:0]          dsr_q;
	logic [DIV_W-1:0]     quo_q;
	logic                 done_q;
	logic [32:0]          trial;
	logic [32:0]          diff;
	logic                 fits;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign diff = trial - {1'b0, dsr_q};
	assign fits = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q <= DIV_CNT_W'(DIV_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[31:0] : trial[31:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;
endmodule

// ===== rtl/rbfk_datapath.sv =====
// Datapath: width register, difference store, distance sum, exp and gradient.
// Depends on rbfk_pkg, rbfk_ram and rbfk_div.
`timescale 1ns / 1ps
module rbfk_datapath #(
	parameter int MAX_DIM = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [31:0]         cfg_wdata,
	input  logic signed [15:0]  x_elem,
	input  logic signed [15:0]  y_elem,
	input  rbfk_pkg::rbfk_cmd_t cmd,
	output rbfk_pkg::rbfk_stat_t stat,
	output logic                result_valid,
	output logic signed [31:0]  grad_elem,
	output logic [15:0]         kernel_value,
	output logic                last_out
);
	import rbfk_pkg::*;

	localparam int CW = $clog2(MAX_DIM + 1);
	localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

	logic [31:0]       width_q;
	logic [31:0]       hw;
	logic [47:0]       dist_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     idx_q;
	logic [2:0]        sq_cnt_q;
	logic              zero_q;
	logic [31:0]       s_q;
	logic [31:0]       s2_q;
	logic [31:0]       s3_q;
	logic [31:0]       d6_q;
	logic [31:0]       p_q;
	logic [15:0]       val_q;
	logic              valid_q;
	logic [31:0]       grad_q;
	logic              last_q;

	logic signed [16:0] diff;
	logic [33:0]        diff_sq;
	logic               room;
	logic [16:0]        rd_diff;
	logic [16:0]        mag;
	logic [32:0]        gprod;
	logic [39:0]        gnum;
	logic [DIV_W-1:0]   dvd;
	logic [31:0]        dvs;
	logic               div_done;
	logic [DIV_W-1:0]   quo;
	logic [63:0]        prod_s2;
	logic [63:0]        prod_s3;
	logic [64:0]        prod_d6;
	logic [63:0]        prod_p;
	logic [32:0]        vsum;
	logic [17:0]        vt;
	logic [31:0]        gsat;

	assign hw = (width_q == '0) ? 32'd1 : width_q;
	assign diff = 17'(x_elem) - 17'(y_elem);
	assign diff_sq = 34'(diff) * 34'(diff);
	assign room = (count_q < CW'(MAX_DIM));

	rbfk_ram #(.WIDTH(17), .DEPTH(MAX_DIM)) u_store (
		.clk   (clk),
		.we    (cmd.load && room),
		.waddr (count_q[AW-1:0]),
		.wdata (diff),
		.re    (cmd.rd),
		.raddr (idx_q[AW-1:0]),
		.rdata (rd_diff)
	);

	assign mag = rd_diff[16] ? (~rd_diff + 17'd1) : rd_diff;
	assign gprod = 33'(mag) * 33'(val_q);
	assign gnum = {1'b0, gprod, 6'b0} + {9'b0, hw[31:1]};

	always_comb begin
		case (cmd.div_sel)
			SEL_R: begin
				dvd = {dist_q, 8'b0};
				dvs = hw;
			end
			default: begin
				dvd = DIV_W'(gnum);
				dvs = hw;
			end
		endcase
	end

	rbfk_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (cmd.div_go),
		.dividend (dvd),
		.divisor  (dvs),
		.done     (div_done),
		.quotient (quo)
	);

	assign prod_s2 = 64'(s_q) * 64'(s_q);
	assign prod_s3 = 64'(s2_q) * 64'(s_q);
	assign prod_d6 = 65'(s3_q) * 65'(RECIP_SIX);
	assign prod_p = 64'(p_q) * 64'(p_q) + 64'h2000_0000;
	assign vsum = 33'(p_q) + 33'h4000;
	assign vt = vsum[32:15];

	always_comb begin
		if (rd_diff[16]) begin
			gsat = (quo > SAT_POS) ? 32'h7fff_ffff : quo[31:0];
		end else begin
			gsat = (quo > SAT_NEG) ? 32'h8000_0000 : (32'd0 - quo[31:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 32'd65536;
			dist_q <= '0;
			count_q <= '0;
			idx_q <= '0;
			sq_cnt_q <= '0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.emit;
			if (cfg_we) begin
				width_q <= cfg_wdata;
			end
			if (cmd.load && room) begin
				count_q <= count_q + 1'b1;
				dist_q <= dist_q + 48'(diff_sq);
			end
			if (cmd.set_p) begin
				sq_cnt_q <= '0;
			end else if (cmd.square) begin
				sq_cnt_q <= sq_cnt_q + 1'b1;
			end
			if (cmd.set_val) begin
				idx_q <= '0;
			end else if (cmd.emit) begin
				idx_q <= idx_q + 1'b1;
				if (stat.idx_last) begin
					count_q <= '0;
					dist_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_s) begin
			zero_q <= (quo >= EXP_LIMIT);
			s_q <= {quo[25:0], 6'b0};
		end
		if (cmd.mul_s2) begin
			s2_q <= prod_s2[61:30];
		end
		if (cmd.mul_s3) begin
			s3_q <= prod_s3[61:30];
		end
		if (cmd.div_six) begin
			d6_q <= {2'b0, prod_d6[64:35]};
		end
		if (cmd.set_p) begin
			p_q <= ONE_Q30 + (s2_q >> 1) - s_q - d6_q;
		end else if (cmd.square) begin
			p_q <= prod_p[61:30];
		end
		if (cmd.set_val) begin
			val_q <= zero_q ? 16'd0 : ((vt > VAL_MAX) ? VAL_MAX[15:0] : vt[15:0]);
		end
		if (cmd.emit) begin
			grad_q <= gsat;
			last_q <= stat.idx_last;
		end
	end

	assign stat.div_done = div_done;
	assign stat.sq_last = (sq_cnt_q == 3'd7);
	assign stat.idx_last = (idx_q == count_q - 1'b1);

	assign result_valid = valid_q;
	assign grad_elem = grad_q;
	assign kernel_value = val_q;
	assign last_out = last_q;
endmodule

// ===== rtl/rbfk_ctrl.sv =====
// Controller state machine: load, distance divide, exp sequence, gradient pass.
// Depends on rbfk_pkg.
`timescale 1ns / 1ps
module rbfk_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 last_in,
	input  rbfk_pkg::rbfk_stat_t stat,
	output rbfk_pkg::rbfk_cmd_t  cmd,
	output logic                 busy
);
	import rbfk_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_RGO   = 4'd1;
	localparam logic [3:0] ST_RWAIT = 4'd2;
	localparam logic [3:0] ST_CAPS  = 4'd3;
	localparam logic [3:0] ST_S2    = 4'd4;
	localparam logic [3:0] ST_S3    = 4'd5;
	localparam logic [3:0] ST_D6    = 4'd6;
	localparam logic [3:0] ST_SETP  = 4'd8;
	localparam logic [3:0] ST_SQ    = 4'd9;
	localparam logic [3:0] ST_SETV  = 4'd10;
	localparam logic [3:0] ST_RD    = 4'd11;
	localparam logic [3:0] ST_GGO   = 4'd12;
	localparam logic [3:0] ST_GWAIT = 4'd13;
	localparam logic [3:0] ST_EMIT  = 4'd14;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		cmd = '0;
		cmd.div_sel = SEL_R;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = start;
				if (start && last_in) begin
					state_d = ST_RGO;
				end
			end
			ST_RGO: begin
				cmd.div_go = 1'b1;
				state_d = ST_RWAIT;
			end
			ST_RWAIT: begin
				if (stat.div_done) begin
					state_d = ST_CAPS;
				end
			end
			ST_CAPS: begin
				cmd.cap_s = 1'b1;
				state_d = ST_S2;
			end
			ST_S2: begin
				cmd.mul_s2 = 1'b1;
				state_d = ST_S3;
			end
			ST_S3: begin
				cmd.mul_s3 = 1'b1;
				state_d = ST_D6;
			end
			ST_D6: begin
				cmd.div_six = 1'b1;
				state_d = ST_SETP;
			end
			ST_SETP: begin
				cmd.set_p = 1'b1;
				state_d = ST_SQ;
			end
			ST_SQ: begin
				cmd.square = 1'b1;
				if (stat.sq_last) begin
					state_d = ST_SETV;
				end
			end
			ST_SETV: begin
				cmd.set_val = 1'b1;
				state_d = ST_RD;
			end
			ST_RD: begin
				cmd.rd = 1'b1;
				state_d = ST_GGO;
			end
			ST_GGO: begin
				cmd.div_go = 1'b1;
				cmd.div_sel = SEL_G;
				state_d = ST_GWAIT;
			end
			ST_GWAIT: begin
				cmd.div_sel = SEL_G;
				if (stat.div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				state_d = stat.idx_last ? ST_IDLE : ST_RD;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);
endmodule

// ===== rtl/rbf_kernel_value_and_gradient.sv =====
// RBF kernel value and gradient, top level. Depends on rbfk_pkg, rbfk_ctrl, rbfk_datapath.
// Loading takes one element pair per cycle while busy is low.
// After the last pair: distance divide (start, 56 quotient bits, done), capture, s^2 and s^3
// multiply steps, 1 divide-by-six step, 10 exp steps, then per result a read, a gradient
// divide (start, 56 quotient bits, done) and a strobe. Results are one-cycle strobes; the
// receiver cannot stall. Reset is asynchronous, active low, clears control state and sets
// the width register to 1.0.
`timescale 1ns / 1ps
module rbf_kernel_value_and_gradient #(
	parameter int MAX_DIM = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [31:0]        cfg_wdata,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] x_elem,
	input  logic signed [15:0] y_elem,
	input  logic               last_in,
	output logic               result_valid,
	output logic signed [31:0] grad_elem,
	output logic [15:0]        kernel_value,
	output logic               last_out
);
	import rbfk_pkg::*;

	rbfk_cmd_t  cmd;
	rbfk_stat_t stat;

	rbfk_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.last_in (last_in),
		.stat    (stat),
		.cmd     (cmd),
		.busy    (busy)
	);

	rbfk_datapath #(.MAX_DIM(MAX_DIM)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.x_elem       (x_elem),
		.y_elem       (y_elem),
		.cmd          (cmd),
		.stat         (stat),
		.result_valid (result_valid),
		.grad_elem    (grad_elem),
		.kernel_value (kernel_value),
		.last_out     (last_out)
	);
endmodule
